FILE: src/kmp_stream_matcher_macros.svh
// Assertion macros for the KMP stream matcher.
`ifndef KMP_STREAM_MATCHER_MACROS_SVH
`define KMP_STREAM_MATCHER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define KMP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define KMP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: src/kmp_pkg.sv
// Shared types and constants of the KMP stream matcher.
package kmp_pkg;

    localparam int PATTERN_MAX_DEF = 64;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CMP
    } t_state;

endpackage

FILE: src/kmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/kmp_stream_matcher.sv
// Results: clear, unused command, pattern full, empty pattern and the first append
//   are registered in the cycle after accept; other appends and text bytes walk the
//   failure chain, each step a fetch state then a compare state, 1 to pattern_length steps.
// Flow: one item at a time, taken only when the output register is empty or
//   drains that cycle; no new item is taken while a walk is under way.
// Reset (synchronous, active low) clears lengths, counters and handshake; memories keep data.
`include "kmp_stream_matcher_macros.svh"

module kmp_stream_matcher
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [1:0]  i_s_tuser,   // [1:0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] match_position
    output logic [2:0]  o_m_tuser    // [0] match_found, [2:1] status
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    t_state        r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_psl, n_psl;
    logic [LW-1:0] r_matched, n_matched;
    logic [31:0]   r_text_idx, n_text_idx;
    logic [LW-1:0] r_k, n_k;
    logic [7:0]    r_byte, n_byte;
    logic          r_is_text, n_is_text;

    logic          r_out_valid, n_out_valid;
    logic          r_found, n_found;
    logic [31:0]   r_pos, n_pos;
    t_status       r_status, n_status;

    logic          accept;
    logic          out_free;
    logic          pat_we, fail_we;
    logic [AW-1:0] pat_waddr;
    logic [7:0]    pat_wdata;
    logic [LW-1:0] fail_wdata;
    logic [AW-1:0] pat_raddr, fail_raddr;
    logic [7:0]    pat_rdata;
    logic [LW-1:0] fail_rdata;
    logic [LW-1:0] k_step;
    logic [LW-1:0] k_prev;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    assign k_prev     = LW'(r_k - 1'b1);
    assign pat_raddr  = r_k[AW-1:0];
    assign fail_raddr = k_prev[AW-1:0];
    assign k_step     = LW'(r_k + 1'b1);

    kmp_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (pat_waddr),
        .i_wdata (pat_wdata),
        .i_raddr (pat_raddr),
        .o_rdata (pat_rdata)
    );

    kmp_ram #(.WIDTH(LW), .DEPTH(PATTERN_MAX)) u_failure_ram (
        .i_clk   (i_clk),
        .i_we    (fail_we),
        .i_waddr (pat_waddr),
        .i_wdata (fail_wdata),
        .i_raddr (fail_raddr),
        .o_rdata (fail_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_psl       <= '0;
            r_matched   <= '0;
            r_text_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_psl       <= n_psl;
            r_matched   <= n_matched;
            r_text_idx  <= n_text_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_byte    <= n_byte;
        r_is_text <= n_is_text;
        r_found   <= n_found;
        r_pos     <= n_pos;
        r_status  <= n_status;
    end

    always_comb begin
        logic [LW-1:0] k_final;
        n_state     = r_state;
        n_len       = r_len;
        n_psl       = r_psl;
        n_matched   = r_matched;
        n_text_idx  = r_text_idx;
        n_k         = r_k;
        n_byte      = r_byte;
        n_is_text   = r_is_text;
        n_out_valid = r_out_valid && !i_m_tready;
        n_found     = r_found;
        n_pos       = r_pos;
        n_status    = r_status;
        pat_we      = 1'b0;
        fail_we     = 1'b0;
        pat_waddr   = r_len[AW-1:0];
        pat_wdata   = r_byte;
        fail_wdata  = '0;
        k_final     = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_byte    = i_s_tdata;
                    n_found   = 1'b0;
                    n_pos     = '0;
                    n_status  = STAT_OK;
                    n_is_text = 1'b0;
                    case (t_cmd'(i_s_tuser))
                        CMD_CLEAR: begin
                            n_len       = '0;
                            n_psl       = '0;
                            n_matched   = '0;
                            n_text_idx  = '0;
                            n_out_valid = 1'b1;
                        end
                        CMD_APPEND: begin
                            n_text_idx = '0;
                            n_matched  = '0;
                            if (r_len >= LW'(PATTERN_MAX)) begin
                                n_status    = STAT_FULL;
                                n_out_valid = 1'b1;
                            end else if (r_len == '0) begin
                                // First byte: no chain to walk
                                pat_we      = 1'b1;
                                fail_we     = 1'b1;
                                pat_wdata   = i_s_tdata;
                                fail_wdata  = '0;
                                n_psl       = '0;
                                n_len       = LW'(1);
                                n_out_valid = 1'b1;
                            end else begin
                                n_k     = r_psl;
                                n_state = ST_FETCH;
                            end
                        end
                        CMD_TEXT: begin
                            if (r_len == '0) begin
                                n_status    = STAT_EMPTY;
                                n_out_valid = 1'b1;
                            end else begin
                                n_is_text = 1'b1;
                                n_k       = (r_matched >= r_len) ? '0 : r_matched;
                                n_state   = ST_FETCH;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (pat_rdata != r_byte && r_k != '0) begin
                    // Follow the failure link and retry
                    n_k     = fail_rdata;
                    n_state = ST_FETCH;
                end else begin
                    k_final     = (pat_rdata == r_byte) ? k_step : '0;
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    if (r_is_text) begin
                        n_text_idx = r_text_idx + 32'd1;
                        if (k_final == r_len) begin
                            n_found   = 1'b1;
                            n_pos     = r_text_idx + 32'd1 - 32'(r_len);
                            n_matched = r_psl;
                        end else begin
                            n_matched = k_final;
                        end
                    end else begin
                        pat_we     = 1'b1;
                        fail_we    = 1'b1;
                        fail_wdata = k_final;
                        n_psl      = k_final;
                        n_len      = LW'(r_len + 1'b1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_pos;
    assign o_m_tuser  = {r_status, r_found};

    `KMP_ASSERT(a_walk_in_range, (r_state != ST_IDLE) |-> (r_k < r_len), "walk index past pattern")
    `KMP_ASSERT(a_busy_not_ready, (r_state != ST_IDLE) |-> !o_s_tready, "ready while walking")
    `KMP_ASSERT(a_len_bound, r_len <= LW'(PATTERN_MAX), "pattern length overflow")
    `KMP_ASSERT(a_matched_bound, (r_matched < r_len) || (r_matched == '0), "matched count too large")

endmodule
